// ----- rtl/core/acc_pkg.sv -----
// ----------------------------------------------------------------------------
// Actuator channel controller package
// Shared codes, controller/datapath handshake types and the mode decode.
// ----------------------------------------------------------------------------
`default_nettype none

package acc_pkg;

  localparam logic [1:0] OP_ACTUATE = 2'd0;
  localparam logic [1:0] OP_SCHEDULE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_SENSE = 2'd3;

  localparam logic [2:0] CMD_RETRACT = 3'd0;
  localparam logic [2:0] CMD_EXTEND = 3'd1;
  localparam logic [2:0] CMD_TIMED_RETRACT = 3'd2;
  localparam logic [2:0] CMD_TIMED_EXTEND = 3'd3;
  localparam logic [2:0] CMD_ON = 3'd4;
  localparam logic [2:0] CMD_OFF = 3'd5;

  localparam logic [1:0] DRIVE_BACK = 2'd0;
  localparam logic [1:0] DRIVE_FWD = 2'd1;
  localparam logic [1:0] DRIVE_STOP = 2'd2;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_MIN_RUN = 1'b1;

  localparam logic [11:0] THRESHOLD_RESET = 12'd100;
  localparam logic [15:0] MIN_RUN_RESET = 16'd100;

  typedef struct packed {
    logic load;
    logic exec;
    logic clk_inc;
    logic ch_adv;
    logic ch_stop;
    logic q_fire;
    logic q_adv;
    logic flush;
  } acc_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       step_ok;
    logic       held_valid;
    logic       out_free;
    logic       ch_expired;
    logic       ch_last;
    logic       q_end;
    logic       q_due;
  } acc_status_t;

  function automatic logic [1:0] drive_of(input logic [2:0] m);
    logic [1:0] d;
    case (m)
      CMD_RETRACT, CMD_TIMED_RETRACT: d = DRIVE_BACK;
      CMD_EXTEND, CMD_TIMED_EXTEND, CMD_ON: d = DRIVE_FWD;
      default: d = DRIVE_STOP;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/acc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Actuator channel controller sequencer
// Steps each input through execute, or a tick through clock advance, channel walk and queue walk.
// ----------------------------------------------------------------------------
`default_nettype none

module acc_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  acc_pkg::acc_status_t sts,
  output acc_pkg::acc_cmd_t    cmd
);
  import acc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_INC, S_CHAN, S_QUEUE, S_FIN
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.op == OP_TICK) begin
          state_next = S_INC;
        end else if (sts.step_ok) begin
          cmd.exec = 1'b1;
          state_next = S_FIN;
        end
      end
      S_INC: begin
        cmd.clk_inc = 1'b1;
        state_next = S_CHAN;
      end
      S_CHAN: begin
        if (!sts.ch_expired || sts.step_ok) begin
          cmd.ch_stop = sts.ch_expired;
          cmd.ch_adv = 1'b1;
          if (sts.ch_last) state_next = S_QUEUE;
        end
      end
      S_QUEUE: begin
        if (sts.q_end) begin
          state_next = S_FIN;
        end else if (sts.q_due) begin
          cmd.q_fire = sts.step_ok;
        end else begin
          cmd.q_adv = 1'b1;
        end
      end
      S_FIN: begin
        if (!sts.held_valid) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/acc_dpath.sv -----
// ----------------------------------------------------------------------------
// Actuator channel controller datapath
// Channel table, pending queue, clock, held result and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module acc_dpath #(
  parameter int NUM_CHANNELS = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  acc_pkg::acc_cmd_t    cmd,
  output acc_pkg::acc_status_t sts,
  input  wire                  cfg_write,
  input  wire                  cfg_index,
  input  wire  [15:0]          cfg_data,
  input  wire  [1:0]           operation,
  input  wire  [2:0]           channel,
  input  wire  [2:0]           command,
  input  wire  [31:0]          duration_ms,
  input  wire  [31:0]          delay_ms,
  input  wire  [11:0]          current_ma,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [2:0]           out_channel,
  output logic [1:0]           drive,
  output logic [2:0]           mode,
  output logic [1:0]           reported_state,
  output logic                 status,
  output logic                 last
);
  import acc_pkg::*;

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [11:0] threshold;
  logic [15:0] min_run;

  logic [2:0]  ch_mode [NUM_CHANNELS];
  logic [31:0] stamp [NUM_CHANNELS];
  logic [31:0] run_len [NUM_CHANNELS];
  logic [31:0] clock_ms;

  logic [2:0]  q_ch [QUEUE_DEPTH];
  logic [2:0]  q_cmd [QUEUE_DEPTH];
  logic [31:0] q_dur [QUEUE_DEPTH];
  logic [31:0] q_due [QUEUE_DEPTH];
  logic [NW-1:0] q_count;
  logic [NW-1:0] qi;
  logic [CW-1:0] ci;

  logic [1:0]  r_op;
  logic [2:0]  r_ch;
  logic [2:0]  r_cmd;
  logic [31:0] r_dur;
  logic [31:0] r_dly;
  logic [11:0] r_cur;

  logic       h_valid;
  logic [2:0] h_ch;
  logic [2:0] h_mode;
  logic       h_status;

  logic [31:0] r_ch_wide, ci_wide, qc_wide;
  logic [CW-1:0] rd_idx, in_idx, q_idx_ch;
  logic [QW-1:0] q_rd;
  logic        in_ok, q_ok, q_full, stop_sense, out_free, step_ok, push;
  logic [2:0]  rd_mode, new_mode, qc, qm;
  logic [31:0] elapsed;

  assign r_ch_wide = 32'(r_ch);
  assign in_idx = r_ch_wide[CW-1:0];
  assign in_ok = r_ch_wide < NUM_CHANNELS;
  assign ci_wide = 32'(ci);
  assign rd_idx = (r_op == OP_TICK) ? ci : in_idx;
  assign rd_mode = ch_mode[rd_idx];
  assign elapsed = clock_ms - stamp[rd_idx];

  assign q_rd = qi[QW-1:0];
  assign qc = q_ch[q_rd];
  assign qm = q_cmd[q_rd];
  assign qc_wide = 32'(qc);
  assign q_idx_ch = qc_wide[CW-1:0];
  assign q_ok = qc_wide < NUM_CHANNELS;
  assign q_full = 32'(q_count) >= QUEUE_DEPTH;

  assign stop_sense = in_ok && (rd_mode == CMD_RETRACT || rd_mode == CMD_EXTEND) &&
                      (r_cur < threshold) && (elapsed > {16'd0, min_run});

  assign out_free = !out_valid || out_ready;
  assign step_ok = !h_valid || out_free;
  assign push = (h_valid && (cmd.exec || cmd.ch_stop || cmd.q_fire)) || cmd.flush;

  always_comb begin
    case (r_op)
      OP_ACTUATE: new_mode = in_ok ? r_cmd : CMD_OFF;
      OP_SCHEDULE: new_mode = in_ok ? rd_mode : CMD_OFF;
      OP_SENSE: new_mode = (in_ok && !stop_sense) ? rd_mode : CMD_OFF;
      default: new_mode = CMD_OFF;
    endcase
  end

  always_comb begin
    sts.op = r_op;
    sts.step_ok = step_ok;
    sts.held_valid = h_valid;
    sts.out_free = out_free;
    sts.ch_expired = (rd_mode == CMD_TIMED_RETRACT || rd_mode == CMD_TIMED_EXTEND) &&
                     (elapsed > run_len[rd_idx]);
    sts.ch_last = ci_wide == NUM_CHANNELS - 1;
    sts.q_end = qi >= q_count;
    sts.q_due = clock_ms > q_due[q_rd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      min_run <= MIN_RUN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD: threshold <= cfg_data[11:0];
        REG_MIN_RUN: min_run <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_op <= operation;
      r_ch <= channel;
      r_cmd <= (command > CMD_OFF) ? CMD_OFF : command;
      r_dur <= duration_ms;
      r_dly <= delay_ms;
      r_cur <= current_ma;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ch_mode[i] <= CMD_OFF;
        stamp[i] <= '0;
        run_len[i] <= '0;
      end
      clock_ms <= '0;
    end else begin
      if (cmd.clk_inc) clock_ms <= clock_ms + 32'd1;
      if (cmd.exec && in_ok && r_op == OP_ACTUATE) begin
        ch_mode[in_idx] <= r_cmd;
        run_len[in_idx] <= r_dur;
        stamp[in_idx] <= clock_ms;
      end
      if (cmd.exec && r_op == OP_SENSE && stop_sense) ch_mode[in_idx] <= CMD_OFF;
      if (cmd.ch_stop) begin
        ch_mode[ci] <= CMD_OFF;
        run_len[ci] <= '0;
      end
      if (cmd.q_fire && q_ok) begin
        ch_mode[q_idx_ch] <= qm;
        run_len[q_idx_ch] <= q_dur[q_rd];
        stamp[q_idx_ch] <= clock_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && r_op == OP_SCHEDULE && in_ok && !q_full) begin
      q_ch[q_count[QW-1:0]] <= r_ch;
      q_cmd[q_count[QW-1:0]] <= r_cmd;
      q_dur[q_count[QW-1:0]] <= r_dur;
      q_due[q_count[QW-1:0]] <= r_dly + clock_ms;
    end else if (cmd.q_fire) begin
      for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
        if (j >= 32'(qi)) begin
          q_ch[j] <= q_ch[j + 1];
          q_cmd[j] <= q_cmd[j + 1];
          q_dur[j] <= q_dur[j + 1];
          q_due[j] <= q_due[j + 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
      qi <= '0;
      ci <= '0;
    end else begin
      if (cmd.load) begin
        qi <= '0;
        ci <= '0;
      end
      if (cmd.ch_adv) ci <= ci + 1'b1;
      if (cmd.q_adv) qi <= qi + 1'b1;
      if (cmd.exec && r_op == OP_SCHEDULE && in_ok && !q_full) q_count <= q_count + 1'b1;
      if (cmd.q_fire) q_count <= q_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
        out_channel <= h_ch;
        mode <= h_mode;
        status <= h_status;
        last <= cmd.flush;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.exec) begin
        h_valid <= 1'b1;
        h_ch <= r_ch;
        h_mode <= new_mode;
        h_status <= (r_op == OP_SCHEDULE) && in_ok && q_full;
      end else if (cmd.ch_stop) begin
        h_valid <= 1'b1;
        h_ch <= ci_wide[2:0];
        h_mode <= CMD_OFF;
        h_status <= 1'b0;
      end else if (cmd.q_fire) begin
        h_valid <= 1'b1;
        h_ch <= qc;
        h_mode <= q_ok ? qm : CMD_OFF;
        h_status <= 1'b0;
      end else if (cmd.flush) begin
        h_valid <= 1'b0;
      end
    end
  end

  assign drive = drive_of(mode);
  assign reported_state = drive_of(mode);

endmodule

`default_nettype wire

// ----- rtl/core/actuator_channel_controller_top.sv -----
// Commands, schedules and samples go input registers, held result, output register.
// A tick advances the clock, then walks every channel and then every pending entry.
// The queue walk takes one entry per cycle, fired or not, unless a due entry is held up.
// Throughput: one input item at a time; the next is taken once all results are queued.
// Output stalls hold each result step. Reset (synchronous, active high) turns all channels
// off, clears the clock, empties the pending queue and restores both registers to 100.
// ----------------------------------------------------------------------------
// Actuator channel controller
// Multi-channel actuator timing controller with a delayed command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module actuator_channel_controller_top #(
  parameter int NUM_CHANNELS = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_write,
  input  wire         cfg_index,
  input  wire  [15:0] cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  operation,
  input  wire  [2:0]  channel,
  input  wire  [2:0]  command,
  input  wire  [31:0] duration_ms,
  input  wire  [31:0] delay_ms,
  input  wire  [11:0] current_ma,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  out_channel,
  output logic [1:0]  drive,
  output logic [2:0]  mode,
  output logic [1:0]  reported_state,
  output logic        status,
  output logic        last
);
  import acc_pkg::*;

  acc_cmd_t    cmd;
  acc_status_t sts;

  acc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  acc_dpath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .operation      (operation),
    .channel        (channel),
    .command        (command),
    .duration_ms    (duration_ms),
    .delay_ms       (delay_ms),
    .current_ma     (current_ma),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .drive          (drive),
    .mode           (mode),
    .reported_state (reported_state),
    .status         (status),
    .last           (last)
  );

endmodule

`default_nettype wire

// ----- rtl/core/acc_checker.sv -----
// ----------------------------------------------------------------------------
// Actuator channel controller port checker
// Observes the top-level ports and flags illegal result beats and busy input accepts.
// ----------------------------------------------------------------------------
`default_nettype none

module acc_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [2:0]  out_channel,
  input wire [1:0]  drive,
  input wire [2:0]  mode,
  input wire [1:0]  reported_state,
  input wire        status,
  input wire        last
);
  import acc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(mode) &&
    $stable(status) && $stable(last))
    else $error("result beat changed while stalled");

  a_state_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> drive == reported_state)
    else $error("drive and reported state disagree");

  a_off_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode == CMD_OFF |-> drive == DRIVE_STOP)
    else $error("off channel not stopped");

  a_drop_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last)
    else $error("dropped schedule beat not final");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new item taken while busy");

endmodule

bind actuator_channel_controller_top acc_checker u_acc_checker (.*);

`default_nettype wire

// ----- tb/tb_actuator_channel_controller_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Actuator channel controller regression
// Drives random and directed commands, schedules, ticks and current samples
// through the block, predicts every result beat and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_actuator_channel_controller_top;
  import acc_pkg::*;

  localparam int NCH = 8;
  localparam int QD = 16;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  ch;
    logic [2:0]  cmd;
    logic [31:0] dur;
    logic [31:0] dly;
    logic [11:0] cur;
  } beat_in_t;

  typedef struct packed {
    logic [2:0] ch;
    logic [1:0] drv;
    logic [2:0] md;
    logic [1:0] rs;
    logic       st;
    logic       lst;
  } beat_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] operation = '0;
  logic [2:0] channel = '0;
  logic [2:0] command = '0;
  logic [31:0] duration_ms = '0;
  logic [31:0] delay_ms = '0;
  logic [11:0] current_ma = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_channel;
  logic [1:0] drive;
  logic [2:0] mode;
  logic [1:0] reported_state;
  logic status;
  logic last;

  actuator_channel_controller_top dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .channel(channel), .command(command),
    .duration_ms(duration_ms), .delay_ms(delay_ms), .current_ma(current_ma),
    .out_valid(out_valid), .out_ready(out_ready), .out_channel(out_channel),
    .drive(drive), .mode(mode), .reported_state(reported_state),
    .status(status), .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state.
  logic [11:0] thresh_ma;
  logic [15:0] min_run;
  logic [2:0]  ch_mode [NCH];
  logic [31:0] ch_start [NCH];
  logic [31:0] ch_len [NCH];
  logic [31:0] now_ms;
  logic [2:0]  q_ch [$];
  logic [2:0]  q_cmd [$];
  logic [31:0] q_dur [$];
  logic [31:0] q_due [$];

  beat_in_t  pending_beats [$];
  beat_out_t expected_beats [$];
  int errors = 0;
  bit tx_hold = 1'b0;
  int idle_run = 0;
  bit accepted_now = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic void push_result(logic [2:0] ch, logic [2:0] md, logic st);
    beat_out_t b;
    b.ch = ch;
    b.md = md;
    b.drv = drive_of(md);
    b.rs = drive_of(md);
    b.st = st;
    b.lst = 1'b0;
    expected_beats.push_back(b);
  endfunction

  function automatic void predict_beat(beat_in_t b);
    logic [2:0] c;
    int n0;
    int i;
    bit st;
    n0 = expected_beats.size();
    c = (b.cmd > CMD_OFF) ? CMD_OFF : b.cmd;
    case (b.op)
      OP_ACTUATE: begin
        ch_mode[b.ch] = c;
        ch_len[b.ch] = b.dur;
        ch_start[b.ch] = now_ms;
        push_result(b.ch, ch_mode[b.ch], 1'b0);
      end
      OP_SCHEDULE: begin
        st = 1'b0;
        if (q_ch.size() >= QD) begin
          st = 1'b1;
        end else begin
          q_ch.push_back(b.ch);
          q_cmd.push_back(c);
          q_dur.push_back(b.dur);
          q_due.push_back(b.dly + now_ms);
        end
        push_result(b.ch, ch_mode[b.ch], st);
      end
      OP_TICK: begin
        now_ms = now_ms + 32'd1;
        for (i = 0; i < NCH; i++) begin
          if ((ch_mode[i] == CMD_TIMED_RETRACT || ch_mode[i] == CMD_TIMED_EXTEND) &&
              (now_ms - ch_start[i]) > ch_len[i]) begin
            ch_len[i] = '0;
            ch_mode[i] = CMD_OFF;
            push_result(i[2:0], CMD_OFF, 1'b0);
          end
        end
        i = 0;
        while (i < q_ch.size()) begin
          if (now_ms > q_due[i]) begin
            ch_mode[q_ch[i]] = q_cmd[i];
            ch_len[q_ch[i]] = q_dur[i];
            ch_start[q_ch[i]] = now_ms;
            push_result(q_ch[i], q_cmd[i], 1'b0);
            q_ch.delete(i);
            q_cmd.delete(i);
            q_dur.delete(i);
            q_due.delete(i);
          end else begin
            i++;
          end
        end
      end
      default: begin
        if ((ch_mode[b.ch] == CMD_RETRACT || ch_mode[b.ch] == CMD_EXTEND) &&
            b.cur < thresh_ma && (now_ms - ch_start[b.ch]) > {16'd0, min_run}) begin
          ch_mode[b.ch] = CMD_OFF;
        end
        push_result(b.ch, ch_mode[b.ch], 1'b0);
      end
    endcase
    if (expected_beats.size() > n0) expected_beats[$].lst = 1'b1;
  endfunction

  // Driver.
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || accepted_now) begin
        if (in_gap > 0 || tx_hold || pending_beats.size() == 0) begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap <= in_gap - 1;
        end else begin
          beat_in_t b;
          b = pending_beats.pop_front();
          operation <= b.op;
          channel <= b.ch;
          command <= b.cmd;
          duration_ms <= b.dur;
          delay_ms <= b.dly;
          current_ma <= b.cur;
          in_valid <= 1'b1;
          in_gap <= gap_len();
        end
      end
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap <= gap_len();
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    accepted_now <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        beat_in_t b;
        b = {operation, channel, command, duration_ms, delay_ms, current_ma};
        predict_beat(b);
      end
      if (out_valid && out_ready) begin
        beat_out_t e;
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat: channel %0d mode %0d", out_channel, mode);
          errors++;
        end else begin
          e = expected_beats.pop_front();
          if (out_channel !== e.ch) begin
            $error("out_channel: expected %0d actual %0d", e.ch, out_channel); errors++;
          end
          if (drive !== e.drv) begin
            $error("drive: expected %0d actual %0d", e.drv, drive); errors++;
          end
          if (mode !== e.md) begin
            $error("mode: expected %0d actual %0d", e.md, mode); errors++;
          end
          if (reported_state !== e.rs) begin
            $error("reported_state: expected %0d actual %0d", e.rs, reported_state);
            errors++;
          end
          if (status !== e.st) begin
            $error("status: expected %0d actual %0d", e.st, status); errors++;
          end
          if (last !== e.lst) begin
            $error("last: expected %0d actual %0d", e.lst, last); errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run <= 0;
      else idle_run <= idle_run + 1;
      if (idle_run >= STALL_LIMIT) begin
        $display("actuator_channel_controller_top regression: fail");
        $finish;
      end
    end
  end

  function automatic beat_in_t rand_beat();
    beat_in_t b;
    int r;
    b.ch = 3'($urandom_range(0, 7));
    b.cmd = 3'($urandom_range(0, 7));
    b.dur = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 12);
    b.dly = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 10);
    b.cur = ($urandom_range(0, 3) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 200));
    r = $urandom_range(0, 99);
    if (r < 20) b.op = OP_ACTUATE;
    else if (r < 40) b.op = OP_SCHEDULE;
    else if (r < 80) b.op = OP_TICK;
    else b.op = OP_SENSE;
    return b;
  endfunction

  function automatic beat_in_t mk(logic [1:0] op, logic [2:0] ch, logic [2:0] cmd,
                                  logic [31:0] dur, logic [31:0] dly, logic [11:0] cur);
    beat_in_t b;
    b = {op, ch, cmd, dur, dly, cur};
    return b;
  endfunction

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == REG_THRESHOLD) thresh_ma = val[11:0];
    else min_run = val;
  endtask

  task automatic drain();
    while (!(pending_beats.size() == 0 && !in_valid && expected_beats.size() == 0))
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic run_random(int count);
    int k;
    for (k = 0; k < count; k++) pending_beats.push_back(rand_beat());
    drain();
  endtask

  initial begin
    int k;
    thresh_ma = THRESHOLD_RESET;
    min_run = MIN_RUN_RESET;
    now_ms = '0;
    for (k = 0; k < NCH; k++) begin
      ch_mode[k] = CMD_OFF;
      ch_start[k] = '0;
      ch_len[k] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_reg(REG_THRESHOLD, 16'd4095);
    write_reg(REG_MIN_RUN, 16'd0);

    for (k = 0; k < 6; k++)
      pending_beats.push_back(mk(OP_ACTUATE, k[2:0], k[2:0], 32'd2, 32'd0, 12'd0));
    pending_beats.push_back(mk(OP_ACTUATE, 3'd7, 3'd7, 32'hFFFF_FFFF, 32'd0, 12'hFFF));
    pending_beats.push_back(mk(OP_TICK, 3'd0, CMD_RETRACT, 32'd0, 32'd0, 12'd0));
    pending_beats.push_back(mk(OP_SENSE, 3'd0, CMD_RETRACT, 32'd0, 32'd0, 12'd0));
    pending_beats.push_back(mk(OP_TICK, 3'd0, CMD_RETRACT, 32'd0, 32'd0, 12'd0));
    pending_beats.push_back(mk(OP_SENSE, 3'd1, CMD_RETRACT, 32'd0, 32'd0, 12'hFFF));
    pending_beats.push_back(mk(OP_SENSE, 3'd1, CMD_RETRACT, 32'd0, 32'd0, 12'd5));
    for (k = 0; k < 17; k++)
      pending_beats.push_back(mk(OP_SCHEDULE, k[2:0], k[2:0], 32'(k), 32'(k % 3), 12'd0));
    pending_beats.push_back(mk(OP_SCHEDULE, 3'd7, 3'd6, 32'd0, 32'hFFFF_FFFF, 12'd0));
    for (k = 0; k < 4; k++)
      pending_beats.push_back(mk(OP_TICK, 3'd0, CMD_RETRACT, 32'd0, 32'd0, 12'd0));
    drain();

    tx_hold = 1'b1;
    pending_beats.push_back(mk(OP_ACTUATE, 3'd2, CMD_TIMED_EXTEND, 32'd1, 32'd0, 12'd0));
    tx_hold = 1'b0;
    drain();

    run_random(70);
    write_reg(REG_THRESHOLD, 16'd0);
    write_reg(REG_MIN_RUN, 16'd65535);
    run_random(40);
    write_reg(REG_THRESHOLD, 16'd150);
    write_reg(REG_MIN_RUN, 16'd3);
    run_random(90);

    if (errors == 0) begin
      $display("actuator_channel_controller_top regression: pass");
    end else begin
      $display("actuator_channel_controller_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
